// ===== src/bsc_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the B-spline curve evaluator.
// -----------------------------------------------------------------------------
package bsc_pkg;

  localparam int MaxPoints = 64;
  localparam int MaxDegree = 7;
  localparam int FracBits  = 16;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgDegree    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLastPoint = 1'd1;

  typedef enum logic [1:0] {
    CmdKnot = 2'd0,
    CmdCtl  = 2'd1,
    CmdEval = 2'd2,
    CmdNop  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         index;
    logic [1:0]         axis;
    logic signed [31:0] value;
    logic [15:0]        t_param;
  } req_t;

  typedef struct packed {
    logic signed [31:0] coord;
    logic               zero_weight;
  } rsp_t;

  typedef enum logic [4:0] {
    StIdle,
    StInitRd,
    StInitWr,
    StTermRd0,
    StTermRd1,
    StTermRd2,
    StTermRd3,
    StTermA,
    StTermDivA,
    StTermB,
    StTermDivB,
    StTermWr,
    StSumRd,
    StSumMul,
    StSumAcc,
    StFinDiv,
    StDone
  } state_e;

endpackage
`default_nettype wire

// ===== src/bsc_ram.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// bsc_ram
// Single-port synchronous RAM with registered read data.
// -----------------------------------------------------------------------------
module bsc_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== src/bsc_div.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// bsc_div
// Radix-2 restoring signed divider, truncating toward zero, one bit per cycle.
// -----------------------------------------------------------------------------
module bsc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic signed [63:0] den_i,
  output logic                    done_o,
  output logic signed [63:0]      quo_o
);

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    shifted = {rem_q[62:0], quo_q[63]};
    trial   = {1'b0, shifted} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[63] ? 64'(-num_i) : 64'(num_i);
      den_d  = den_i[63] ? 64'(-den_i) : 64'(den_i);
      neg_d  = num_i[63] ^ den_i[63];
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? 64'(-quo_q) : 64'(quo_q);

endmodule
`default_nettype wire

// ===== src/bspline_curve_evaluator_core.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// bspline_curve_evaluator_core
// Cox-de Boor B-spline coordinate evaluator in Q16.16 over knot, control-point
// and basis memories.
// -----------------------------------------------------------------------------
// Sequence: a knot or control write is done at its accepting edge. An evaluate
//   builds the degree-zero indicators, then the basis terms of each degree, each
//   term using the shared 64-step divider for each nonzero span, then the weighted
//   sums and, unless the weight sum is zero, a final quotient in the same divider.
// Throughput: one item at a time; busy is high until the result strobes.
// Reset clears control state and config (degree 2, last point 0); memories
//   hold no reset value. The receiver cannot stall the result.
module bspline_curve_evaluator_core #(
  parameter int MaxPoints = bsc_pkg::MaxPoints,
  parameter int MaxDegree = bsc_pkg::MaxDegree,
  parameter int FracBits  = bsc_pkg::FracBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire bsc_pkg::req_t               req_i,
  output logic                             done_o,
  output bsc_pkg::rsp_t                    rsp_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i
);

  localparam int KnotDepth = MaxPoints + MaxDegree + 1;
  localparam int CtlDepth  = 3 * MaxPoints;
  localparam int TriDepth  = MaxPoints + MaxDegree;
  localparam int KaW = $clog2(KnotDepth);
  localparam int CaW = $clog2(CtlDepth);
  localparam int TaW = $clog2(TriDepth);
  localparam int PtW = $clog2(MaxPoints);
  localparam int DgW = $clog2(MaxDegree + 1);
  localparam int JW  = KaW + 1;
  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  // Configuration: always accepted; clamp on use.
  logic [2:0] degree_q;
  logic [5:0] last_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 3'd2;
      last_q   <= 6'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bsc_pkg::CfgDegree) degree_q <= cfg_data_i[2:0];
      if (cfg_index_i == bsc_pkg::CfgLastPoint) last_q <= cfg_data_i[5:0];
    end
  end

  logic [PtW-1:0] n_w;
  logic [DgW-1:0] p_w;
  always_comb begin
    n_w = (32'(last_q) > 32'(MaxPoints - 1)) ? PtW'(MaxPoints - 1) : PtW'(last_q);
    p_w = (32'(degree_q) > 32'(MaxDegree)) ? DgW'(MaxDegree) : DgW'(degree_q);
  end

  // Memories.
  logic             k_we, c_we, t_we;
  logic [KaW-1:0]   k_addr;
  logic [CaW-1:0]   c_addr;
  logic [TaW-1:0]   t_addr;
  logic [31:0]      k_wdata, c_wdata, t_wdata, k_rdata, c_rdata, t_rdata;

  bsc_ram #(.Width(32), .Depth(KnotDepth)) u_knot (
    .clk_i, .we_i(k_we), .addr_i(k_addr), .wdata_i(k_wdata), .rdata_o(k_rdata));
  bsc_ram #(.Width(32), .Depth(CtlDepth)) u_ctl (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata));
  bsc_ram #(.Width(32), .Depth(TriDepth)) u_tri (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(t_wdata), .rdata_o(t_rdata));

  // Divider shared by basis terms and the final quotient.
  logic               dv_start, dv_done;
  logic signed [63:0] dv_num, dv_den, dv_quo;
  bsc_div u_div (.clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num),
                 .den_i(dv_den), .done_o(dv_done), .quo_o(dv_quo));

  bsc_pkg::state_e state_q, state_d;
  logic [JW-1:0]      j_q, j_d;
  logic [DgW-1:0]     d_q, d_d;
  logic [1:0]         axis_q, axis_d;
  logic signed [31:0] t_q, t_d;
  logic signed [31:0] kj_q, kj_d, kj1_q, kj1_d, kjd_q, kjd_d, kjd1_q, kjd1_d;
  logic signed [31:0] nj_q, nj_d, nj1_q, nj1_d, a_q, a_d;
  logic signed [63:0] prod_q, prod_d, up_q, up_d;
  logic signed [39:0] down_q, down_d;
  logic signed [31:0] ctl_q, ctl_d;
  logic               done_q, done_d;
  bsc_pkg::rsp_t      rsp_q, rsp_d;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Differences saturate to 32 bits.
  logic signed [31:0] diff_num, diff_den;
  logic               den_zero;
  logic signed [63:0] prod_w, madd;
  logic signed [64:0] up_sum;
  logic [JW-1:0]      top_j;
  logic signed [32:0] ab;

  always_comb begin
    top_j = JW'(n_w) + JW'(p_w);
    if (state_q == bsc_pkg::StTermA) begin
      diff_num = sat32(65'(t_q) - 65'(kj_q));
      diff_den = sat32(65'(kjd_q) - 65'(kj_q));
      prod_w   = 64'(diff_num) * 64'(nj_q);
    end else begin
      diff_num = sat32(65'(kjd1_q) - 65'(t_q));
      diff_den = sat32(65'(kjd1_q) - 65'(kj1_q));
      prod_w   = 64'(diff_num) * 64'(nj1_q);
    end
    den_zero = (diff_den == 32'sd0);
    madd     = 64'(ctl_q) * 64'(nj_q);
    up_sum   = 65'(up_q) + 65'(prod_q);
    ab       = 33'(a_q) + 33'(sat32(65'(dv_quo)));
  end

  always_comb begin
    state_d = state_q;
    j_d = j_q; d_d = d_q; axis_d = axis_q; t_d = t_q;
    kj_d = kj_q; kj1_d = kj1_q; kjd_d = kjd_q; kjd1_d = kjd1_q;
    nj_d = nj_q; nj1_d = nj1_q; a_d = a_q; prod_d = prod_q;
    up_d = up_q; down_d = down_q; ctl_d = ctl_q;
    done_d = 1'b0; rsp_d = rsp_q;
    k_we = 1'b0; c_we = 1'b0; t_we = 1'b0;
    k_addr = '0; c_addr = '0; t_addr = '0;
    k_wdata = req_i.value; c_wdata = req_i.value; t_wdata = '0;
    dv_start = 1'b0; dv_num = prod_q; dv_den = 64'(kjd_q);
    busy = (state_q != bsc_pkg::StIdle);

    case (state_q)
      bsc_pkg::StIdle: begin
        if (start) begin
          case (bsc_pkg::cmd_e'(req_i.cmd))
            bsc_pkg::CmdKnot: begin
              k_addr = KaW'(req_i.index);
              k_we   = (32'(req_i.index) < KnotDepth);
            end
            bsc_pkg::CmdCtl: begin
              c_addr = CaW'(32'(req_i.index) * 3 + 32'(req_i.axis));
              c_we   = (32'(req_i.index) < MaxPoints) && (req_i.axis != 2'd3);
            end
            bsc_pkg::CmdEval: begin
              t_d    = 32'((64'(req_i.t_param) << FracBits) >> 16);
              axis_d = req_i.axis;
              j_d    = '0;
              k_addr = '0;
              state_d = bsc_pkg::StInitRd;
            end
            default: ;
          endcase
        end
      end
      // Degree-zero indicators: read k(j), then k(j+1).
      bsc_pkg::StInitRd: begin
        k_addr  = KaW'(j_q + JW'(1));
        kj_d    = k_rdata;
        state_d = bsc_pkg::StInitWr;
      end
      bsc_pkg::StInitWr: begin
        t_addr  = TaW'(j_q);
        t_we    = 1'b1;
        t_wdata = (kj_q <= t_q && t_q <= $signed(k_rdata)) ? One : 32'sd0;
        k_addr  = KaW'(j_q + JW'(1));
        if (j_q == top_j) begin
          j_d = '0;
          d_d = DgW'(1);
          if (p_w == '0) begin
            up_d    = '0;
            down_d  = '0;
            state_d = bsc_pkg::StSumRd;
          end else begin
            k_addr  = '0;
            state_d = bsc_pkg::StTermRd0;
          end
        end else begin
          j_d     = j_q + JW'(1);
          state_d = bsc_pkg::StInitRd;
        end
      end
      // Basis term: read k(j), k(j+1), k(j+d), k(j+d+1), tri(j), tri(j+1).
      bsc_pkg::StTermRd0: begin
        k_addr  = KaW'(j_q);
        t_addr  = TaW'(j_q);
        state_d = bsc_pkg::StTermRd1;
      end
      bsc_pkg::StTermRd1: begin
        kj_d    = k_rdata;
        nj_d    = t_rdata;
        k_addr  = KaW'(j_q + JW'(1));
        t_addr  = TaW'(j_q + JW'(1));
        state_d = bsc_pkg::StTermRd2;
      end
      bsc_pkg::StTermRd2: begin
        kj1_d   = k_rdata;
        nj1_d   = t_rdata;
        k_addr  = KaW'(j_q + JW'(d_q));
        state_d = bsc_pkg::StTermRd3;
      end
      bsc_pkg::StTermRd3: begin
        kjd_d   = k_rdata;
        k_addr  = KaW'(j_q + JW'(d_q) + JW'(1));
        state_d = bsc_pkg::StTermA;
      end
      bsc_pkg::StTermA: begin
        kjd1_d = k_rdata;
        prod_d = prod_w;
        if (den_zero) begin
          a_d     = '0;
          state_d = bsc_pkg::StTermB;
        end else begin
          dv_start = 1'b1;
          dv_num   = prod_w;
          dv_den   = 64'(diff_den);
          state_d  = bsc_pkg::StTermDivA;
        end
      end
      bsc_pkg::StTermDivA: begin
        if (dv_done) begin
          a_d     = sat32(65'(dv_quo));
          state_d = bsc_pkg::StTermB;
        end
      end
      bsc_pkg::StTermB: begin
        if (den_zero) begin
          nj_d    = a_q;
          state_d = bsc_pkg::StTermWr;
        end else begin
          dv_start = 1'b1;
          dv_num   = prod_w;
          dv_den   = 64'(diff_den);
          state_d  = bsc_pkg::StTermDivB;
        end
      end
      bsc_pkg::StTermDivB: begin
        if (dv_done) begin
          nj_d    = sat32(65'(ab));
          state_d = bsc_pkg::StTermWr;
        end
      end
      bsc_pkg::StTermWr: begin
        t_addr  = TaW'(j_q);
        t_we    = 1'b1;
        t_wdata = nj_q;
        if (j_q + JW'(d_q) == top_j) begin
          j_d = '0;
          if (d_q == p_w) begin
            state_d = bsc_pkg::StSumRd;
          end else begin
            d_d     = d_q + DgW'(1);
            state_d = bsc_pkg::StTermRd0;
          end
        end else begin
          j_d     = j_q + JW'(1);
          state_d = bsc_pkg::StTermRd0;
        end
        if (state_d == bsc_pkg::StSumRd) begin
          up_d = '0;
          down_d = '0;
        end
      end
      // Weighted sums over control points.
      bsc_pkg::StSumRd: begin
        t_addr  = TaW'(j_q);
        c_addr  = CaW'(32'(j_q) * 3 + 32'(axis_q));
        state_d = bsc_pkg::StSumMul;
      end
      bsc_pkg::StSumMul: begin
        nj_d    = t_rdata;
        ctl_d   = (axis_q == 2'd3) ? 32'sd0 : $signed(c_rdata);
        state_d = bsc_pkg::StSumAcc;
      end
      bsc_pkg::StSumAcc: begin
        prod_d = madd;
        down_d = down_q + 40'(nj_q);
        state_d = bsc_pkg::StFinDiv;
      end
      bsc_pkg::StFinDiv: begin
        if (up_sum > 65'sh0_7fff_ffff_ffff_ffff) up_d = 64'sh7fff_ffff_ffff_ffff;
        else if (up_sum < -65'sh0_7fff_ffff_ffff_ffff)
          up_d = -64'sh7fff_ffff_ffff_ffff;
        else up_d = up_sum[63:0];
        if (j_q == JW'(n_w)) begin
          if (down_q == '0) begin
            rsp_d.coord = '0;
            rsp_d.zero_weight = 1'b1;
            done_d  = 1'b1;
            state_d = bsc_pkg::StIdle;
          end else begin
            dv_start = 1'b1;
            dv_num   = up_d;
            dv_den   = 64'(down_q);
            state_d  = bsc_pkg::StDone;
          end
        end else begin
          j_d     = j_q + JW'(1);
          state_d = bsc_pkg::StSumRd;
        end
      end
      bsc_pkg::StDone: begin
        if (dv_done) begin
          rsp_d.coord = sat32(65'(dv_quo));
          rsp_d.zero_weight = 1'b0;
          done_d  = 1'b1;
          state_d = bsc_pkg::StIdle;
        end
      end
      default: state_d = bsc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsc_pkg::StIdle;
      done_q  <= 1'b0;
      j_q     <= '0;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      j_q     <= j_d;
      d_q     <= d_d;
    end
  end

  // Datapath registers hold no reset.
  always_ff @(posedge clk_i) begin
    axis_q <= axis_d; t_q <= t_d;
    kj_q <= kj_d; kj1_q <= kj1_d; kjd_q <= kjd_d; kjd1_q <= kjd1_d;
    nj_q <= nj_d; nj1_q <= nj1_d; a_q <= a_d; prod_q <= prod_d;
    up_q <= up_d; down_q <= down_d; ctl_q <= ctl_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result strobes only as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == bsc_pkg::StIdle) else $error("result outside idle");
  // A zero-weight result carries a zero coordinate.
  a_zero_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.zero_weight |-> rsp_o.coord == 32'sd0)
    else $error("zero weight with nonzero coord");
  // The divider is never restarted while its quotient is pending.
  a_div_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |=> !dv_start) else $error("divider restarted");

endmodule
`default_nettype wire
